// File: design/circular_list_store_top_defines.svh
// ----------------------------------------------------------------------------
// circular_list_store_top_defines
// Assertion macros shared by the circular list store RTL. Every macro samples
// on the rising edge of clock and is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LIST_STORE_TOP_DEFINES_SVH
`define CIRCULAR_LIST_STORE_TOP_DEFINES_SVH

// same-cycle implication
`define CLST_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CLST_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/clst_pkg.sv
// ----------------------------------------------------------------------------
// clst_pkg
// Shared sizes, operation and status codes, and ring index helper for the
// circular list store.
// ----------------------------------------------------------------------------
package clst_pkg;

   // list capacity (2 to 64)
   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // payload field widths
   localparam int KIND_W     = 2;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 8;
   localparam int STATUS_W   = 3;
   localparam int ELEMENT_W  = 32;
   localparam int REQ_DATA_W = ((VALUE_W + POS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ELEMENT_W + 7) / 8) * 8;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_INS_FRONT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INS_END   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_LIST      = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_ELEMENT  = 3'd5;

   // slot of the list element at a given offset from the front;
   // front + offset stays below twice the capacity, so one subtract wraps it
   function automatic idx_type slot_of(input idx_type front, input cnt_type offset);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - IDX_W){1'b0}}, front} + {1'b0, offset};
      if (sum >= (CNT_W + 1)'(CAPACITY)) begin
         sum = sum - (CNT_W + 1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// File: design/clst_ram.sv
// ----------------------------------------------------------------------------
// clst_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module clst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// File: design/circular_list_store_top.sv
// ----------------------------------------------------------------------------
// circular_list_store_top
// Circular list store: a ring of up to CAPACITY signed 32-bit values kept in
// one RAM, with insert at front, insert at end, delete at a 1-based position
// and list-all requests.
// ----------------------------------------------------------------------------
// Requests are handled one at a time; req_tready is high only while the block
// is idle. An insert or a rejected request is registered on transfer, decoded
// in S_DECODE and loaded into the output register once that is free. A delete
// at position p in a list of n elements walks the n - p later entries through
// the single RAM read/write port pair, one entry per cycle. A list request
// reads one entry per cycle and delivers n results while rsp_tready stays
// high. The last result of every request has rsp_tlast set, and rsp_tdata is
// zero on results that are not listed elements. The RAM needs no clearing
// after reset; only written entries are ever read.
// ----------------------------------------------------------------------------
`include "circular_list_store_top_defines.svh"

module circular_list_store_top (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [clst_pkg::REQ_DATA_W-1:0] req_tdata,  // value[31:0], position[39:32]
   input  logic [clst_pkg::KIND_W-1:0]     req_tuser,  // kind[1:0]
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [clst_pkg::RSP_DATA_W-1:0] rsp_tdata,  // element[31:0]
   output logic [clst_pkg::STATUS_W-1:0]   rsp_tuser,  // status[2:0]
   output logic                           rsp_tlast
);

   import clst_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECODE  = 3'd1;
   localparam logic [2:0] S_SHIFT   = 3'd2;
   localparam logic [2:0] S_DELDONE = 3'd3;
   localparam logic [2:0] S_LIST    = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [POS_W-1:0]     position_ff, position_in;
   idx_type              front_ff, front_in;
   cnt_type              count_ff, count_in;
   cnt_type              idx_ff, idx_in;
   logic                 wr_pend_ff, wr_pend_in;
   idx_type              wr_dst_ff, wr_dst_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ELEMENT_W-1:0] rsp_element_ff, rsp_element_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 ram_wr_en;
   idx_type              ram_wr_addr;
   logic [VALUE_W-1:0]   ram_wr_data;
   logic                 ram_rd_en;
   idx_type              ram_rd_addr;
   logic [VALUE_W-1:0]   ram_rd_data;

   logic                 out_free;
   logic                 out_load;
   logic [POS_W-1:0]     count_wide;
   logic [POS_W-1:0]     pos_minus1;
   cnt_type              idx_next;
   logic                 list_last;

   // slot storage
   clst_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // helpers
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign count_wide = {{(POS_W - CNT_W){1'b0}}, count_ff};
   assign pos_minus1 = position_ff - POS_W'(1);
   assign idx_next   = idx_ff + CNT_W'(1);
   assign list_last  = (idx_next == count_ff);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      value_in       = value_ff;
      position_in    = position_ff;
      front_in       = front_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      wr_pend_in     = wr_pend_ff;
      wr_dst_in      = wr_dst_ff;
      out_load       = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = wr_dst_ff;
      ram_wr_data    = ram_rd_data;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = front_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in     = req_tuser;
               value_in    = req_tdata[VALUE_W-1:0];
               position_in = req_tdata[VALUE_W+POS_W-1:VALUE_W];
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (kind_ff) inside
               KIND_INS_FRONT, KIND_INS_END: begin
                  if (out_free) begin
                     out_load       = 1'b1;
                     rsp_element_in = '0;
                     rsp_last_in    = 1'b1;
                     state_in       = S_IDLE;
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_INSERTED;
                        ram_wr_en     = 1'b1;
                        ram_wr_data   = value_ff;
                        count_in      = count_ff + CNT_W'(1);
                        if (kind_ff == KIND_INS_FRONT) begin
                           front_in    = (front_ff == '0) ? IDX_W'(CAPACITY - 1)
                                                          : front_ff - IDX_W'(1);
                           ram_wr_addr = front_in;
                        end else begin
                           ram_wr_addr = slot_of(front_ff, count_ff);
                        end
                     end
                  end
               end
               KIND_DELETE: begin
                  if (count_ff == '0 || position_ff == '0 || position_ff > count_wide) begin
                     if (out_free) begin
                        out_load       = 1'b1;
                        rsp_status_in  = (count_ff == '0) ? ST_EMPTY : ST_INVALID;
                        rsp_element_in = '0;
                        rsp_last_in    = 1'b1;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     idx_in     = pos_minus1[CNT_W-1:0];
                     wr_pend_in = 1'b0;
                     state_in   = S_SHIFT;
                  end
               end
               default: begin
                  if (count_ff == '0) begin
                     if (out_free) begin
                        out_load       = 1'b1;
                        rsp_status_in  = ST_EMPTY;
                        rsp_element_in = '0;
                        rsp_last_in    = 1'b1;
                        state_in       = S_IDLE;
                     end
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = front_ff;
                     idx_in      = '0;
                     state_in    = S_LIST;
                  end
               end
            endcase
         end
         S_SHIFT: begin
            // move entry idx+1 down to idx, read and write overlapped
            if (wr_pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wr_dst_ff;
               ram_wr_data = ram_rd_data;
            end
            if (idx_next < count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = slot_of(front_ff, idx_next);
               wr_pend_in  = 1'b1;
               wr_dst_in   = slot_of(front_ff, idx_ff);
               idx_in      = idx_next;
            end else begin
               wr_pend_in = 1'b0;
               state_in   = S_DELDONE;
            end
         end
         S_DELDONE: begin
            if (out_free) begin
               count_in       = count_ff - CNT_W'(1);
               out_load       = 1'b1;
               rsp_status_in  = ST_DELETED;
               rsp_element_in = '0;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_LIST: begin
            // emit the entry the RAM has read out, fetch the following one
            if (out_free) begin
               out_load       = 1'b1;
               rsp_status_in  = ST_ELEMENT;
               rsp_element_in = ram_rd_data;
               rsp_last_in    = list_last;
               if (list_last) begin
                  state_in = S_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = slot_of(front_ff, idx_next);
                  idx_in      = idx_next;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      value_ff       <= value_in;
      position_ff    <= position_in;
      idx_ff         <= idx_in;
      wr_dst_ff      <= wr_dst_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_element_ff);
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `CLST_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY),
                    "element count exceeds capacity")
   `CLST_ASSERT_IMP(a_port_clash, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr,
                    "shift reads and writes the same slot")
   `CLST_ASSERT_NXT(a_insert_count,
                    state_ff == S_DECODE && out_free && count_ff < CNT_W'(CAPACITY) &&
                    (kind_ff == KIND_INS_FRONT || kind_ff == KIND_INS_END),
                    count_ff == $past(count_ff) + CNT_W'(1),
                    "insert did not grow the list by one")
   `CLST_ASSERT_NXT(a_list_end, state_ff == S_LIST && out_load && list_last,
                    state_ff == S_IDLE && rsp_tlast,
                    "list transfer did not end after the last element")

endmodule

// File: verif/tb_circular_list_store_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_list_store_top
// Self-checking bench for the circular list store. A tracker class mirrors
// the ring contents, head slot and element count, and queues the results each
// accepted request should produce. Every result transfer is checked in order
// against that queue. A short directed pass covers the empty, invalid and
// extreme-value cases, then random traffic in grow, shrink and mixed phases
// fills the ring to capacity, drains it and wraps the head slot, with random
// stalls on both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_circular_list_store_top;
   import clst_pkg::*;

   // one expected result transfer
   typedef struct {
      logic [STATUS_W-1:0]  status;
      logic [ELEMENT_W-1:0] element;
      logic                 last;
   } list_result_type;

   typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} traffic_mode_type;

   // ring mirror and queue of awaited results
   class ring_list_tracker;
      logic [VALUE_W-1:0] ring_vals [CAPACITY];
      idx_type            head_slot;
      cnt_type            elem_count;
      list_result_type    awaited_results [$];
      int                 errors;

      function new();
         head_slot  = '0;
         elem_count = '0;
         errors     = 0;
      endfunction

      function idx_type slot_at(input int offset);
         return idx_type'((int'(head_slot) + offset) % CAPACITY);
      endfunction

      function void push_status(input logic [STATUS_W-1:0] status);
         list_result_type r;
         r.status  = status;
         r.element = '0;
         r.last    = 1'b1;
         awaited_results.push_back(r);
      endfunction

      // update the mirror for one accepted request and queue its results
      function void note_request(input logic [KIND_W-1:0] kind,
                                 input logic [VALUE_W-1:0] value,
                                 input logic [POS_W-1:0] position);
         list_result_type r;
         int              i;
         case (kind)
            KIND_INS_FRONT, KIND_INS_END: begin
               if (int'(elem_count) >= CAPACITY) begin
                  push_status(ST_FULL);
               end else begin
                  if (kind == KIND_INS_FRONT) begin
                     head_slot = slot_at(CAPACITY - 1);
                     ring_vals[head_slot] = value;
                  end else begin
                     ring_vals[slot_at(int'(elem_count))] = value;
                  end
                  elem_count = elem_count + 1'b1;
                  push_status(ST_INSERTED);
               end
            end
            KIND_DELETE: begin
               if (elem_count == 0) begin
                  push_status(ST_EMPTY);
               end else if (position == 0 || int'(position) > int'(elem_count)) begin
                  push_status(ST_INVALID);
               end else begin
                  // close the gap by pulling later entries one slot forward
                  for (i = int'(position) - 1; i + 1 < int'(elem_count); i++) begin
                     ring_vals[slot_at(i)] = ring_vals[slot_at(i + 1)];
                  end
                  elem_count = elem_count - 1'b1;
                  push_status(ST_DELETED);
               end
            end
            default: begin
               if (elem_count == 0) begin
                  push_status(ST_EMPTY);
               end else begin
                  for (i = 0; i < int'(elem_count); i++) begin
                     r.status  = ST_ELEMENT;
                     r.element = ring_vals[slot_at(i)];
                     r.last    = (i + 1 == int'(elem_count));
                     awaited_results.push_back(r);
                  end
               end
            end
         endcase
      endfunction

      // compare one result transfer with the oldest awaited result
      function void check_result(input logic [STATUS_W-1:0] status,
                                 input logic [ELEMENT_W-1:0] element,
                                 input logic last);
         list_result_type r;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d %h %0b",
                     $time, status, element, last);
            errors++;
            return;
         end
         r = awaited_results.pop_front();
         if (status !== r.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time, r.status, status);
            errors++;
         end
         if (element !== r.element) begin
            $display("%0t: element mismatch, expected %h, actual %h", $time, r.element, element);
            errors++;
         end
         if (last !== r.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b", $time, r.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // value[31:0], position[39:32]
   logic [KIND_W-1:0]      req_tuser;   // kind[1:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;   // element[31:0]
   logic [STATUS_W-1:0]    rsp_tuser;   // status[2:0]
   logic                   rsp_tlast;

   ring_list_tracker tracker;
   bit               quiet;       // no idling on either side
   bit               calm_tx;     // sender offers back to back
   int               results_seen;

   circular_list_store_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock and initial input values
   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      rsp_tready   = 1'b0;
      quiet        = 1'b0;
      calm_tx      = 1'b0;
      results_seen = 0;
      tracker      = new();
   end

   always #10 clock = ~clock;

   // offer one request and hold it until the transfer
   task automatic offer_request(input logic [KIND_W-1:0] kind,
                                input logic [VALUE_W-1:0] value,
                                input logic [POS_W-1:0] position);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {position, value};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(kind, value, position);
   endtask

   // random idle burst on the request side
   task automatic pause_requests();
      if (!quiet && !calm_tx && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // result side: check transfers and stall at random
   initial begin
      int stall_left;
      int calm_left;
      bit calm;
      bit held;
      stall_left = 0;
      calm_left  = 0;
      calm       = 1'b0;
      held       = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            tracker.check_result(rsp_tuser, rsp_tdata[ELEMENT_W-1:0], rsp_tlast);
            results_seen++;
         end
         if (calm_left == 0) begin
            calm      = ($urandom_range(0, 2) == 0);
            calm_left = $urandom_range(50, 200);
         end else begin
            calm_left--;
         end
         // one long hold-off so the block backs up into the request side
         if (!held && results_seen >= 120) begin
            held       = 1'b1;
            stall_left = 400;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // stimulus
   initial begin
      traffic_mode_type   mode;
      int                 phase_left;
      int                 ins_pct;
      int                 del_pct;
      int                 roll;
      int                 n;
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   position;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list cases
      offer_request(KIND_LIST, 32'h0, 8'd0);
      offer_request(KIND_DELETE, 32'h0, 8'd1);
      offer_request(KIND_DELETE, 32'h0, 8'd0);
      pause_requests();
      // extreme values at both ends
      offer_request(KIND_INS_FRONT, 32'h8000_0000, 8'd0);
      offer_request(KIND_INS_END, 32'h7FFF_FFFF, 8'd255);
      offer_request(KIND_INS_FRONT, 32'h0000_0000, 8'd0);
      offer_request(KIND_INS_END, 32'hFFFF_FFFF, 8'd0);
      offer_request(KIND_LIST, 32'hFFFF_FFFF, 8'd255);
      // position zero, one past the count, and far past it
      offer_request(KIND_DELETE, 32'h0, 8'd0);
      offer_request(KIND_DELETE, 32'h0, 8'd5);
      offer_request(KIND_DELETE, 32'h0, 8'd255);
      pause_requests();
      // delete in the middle, at the end and at the front
      offer_request(KIND_DELETE, 32'h0, 8'd2);
      offer_request(KIND_LIST, 32'h0, 8'd0);
      offer_request(KIND_DELETE, 32'h0, 8'd3);
      offer_request(KIND_DELETE, 32'h0, 8'd1);
      offer_request(KIND_LIST, 32'h0, 8'd0);
      offer_request(KIND_DELETE, 32'h0, 8'd1);
      offer_request(KIND_LIST, 32'h0, 8'd0);
      pause_requests();

      // random traffic; the first phase grows the ring
      mode       = MODE_GROW;
      phase_left = 45;
      for (n = 0; n < 260; n++) begin
         if (phase_left == 0) begin
            roll = $urandom_range(0, 2);
            mode = (roll == 0) ? MODE_GROW : (roll == 1) ? MODE_SHRINK : MODE_MIXED;
            phase_left = $urandom_range(20, 40);
            calm_tx    = ($urandom_range(0, 2) == 0);
         end
         phase_left--;
         quiet = (n >= 225);

         case (mode)
            MODE_GROW:   begin ins_pct = 80; del_pct = 10; end
            MODE_SHRINK: begin ins_pct = 15; del_pct = 70; end
            default:     begin ins_pct = 45; del_pct = 40; end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < ins_pct) begin
            kind = $urandom_range(0, 1) ? KIND_INS_END : KIND_INS_FRONT;
         end else if (roll < ins_pct + del_pct) begin
            kind = KIND_DELETE;
         end else begin
            kind = KIND_LIST;
         end

         case ($urandom_range(0, 9))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            default: value = $urandom;
         endcase

         // mostly valid positions, with zero, one past the end and noise
         case ($urandom_range(0, 9))
            0:       position = 8'd0;
            1:       position = POS_W'(tracker.elem_count) + 1'b1;
            2:       position = POS_W'($urandom_range(0, 255));
            default: position = POS_W'($urandom_range(1, (tracker.elem_count == 0) ?
                                                        1 : int'(tracker.elem_count)));
         endcase

         offer_request(kind, value, position);
         pause_requests();
      end
      req_tvalid <= 1'b0;

      // drain outstanding results, then watch for strays
      while (tracker.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
